// ===== src/pcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsd_pkg: shared types and constants for the pixel composer
// Sample and result types, register indexes, lane control, decode constants
// and the elaboration-time builder for the sRGB decode knots.
// ----------------------------------------------------------------------------
package pcsd_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int RESULT_W   = 25;
  localparam int INDEX_W    = 24;
  localparam int FLAG_W     = 6;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PIPE_DEPTH = 4;
  localparam int KNOT_W     = 24;
  localparam int FRAC_W     = 19;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int LIN_X_W    = 28;
  localparam int LIN_M_W    = 27;
  localparam int LIN_SHIFT  = 36;
  localparam int QUOT_W     = 18;
  localparam int RES_X_W    = RESULT_W + 1;

  localparam int NAN_RED     = 0;
  localparam int NAN_GREEN   = 1;
  localparam int NAN_BLUE    = 2;
  localparam int NAN_ALPHA   = 3;
  localparam int NAN_AMBIENT = 4;
  localparam int NAN_DEPTH   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_AMBIENT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_BACKGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_RED       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_GREEN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_BLUE      = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] result_t;

  typedef struct packed {
    logic use_amb;
    logic amb_nan;
    logic is_back;
  } lane_ctl_t;

  localparam sample_t Q_MAX     = 20'sd524287;
  localparam sample_t Q_MIN     = -20'sd524288;
  localparam sample_t ONE_Q16   = 20'sd65536;
  localparam sample_t LIN_LIMIT = 20'sd2650;
  localparam result_t OUT_MAX   = 25'sd8650752;
  localparam result_t OUT_MIN   = -25'sd65536;

  localparam logic signed [LIN_X_W-1:0] LIN_SLOPE = 28'sd50;
  localparam logic signed [LIN_X_W-1:0] LIN_BIAS  = 28'sd42336579;
  localparam logic [LIN_M_W-1:0]        LIN_RECIP = 27'd106376899;
  localparam logic [RES_X_W-1:0]        LIN_OFFS  = 26'd65536;

  // knot k of a depth-entry table: 65536 * ((8k/depth + 0.055) / 1.055)^2.4
  function automatic logic [KNOT_W-1:0] knot_value(input int unsigned depth,
                                                    input int unsigned k);
    longint unsigned num;
    longint unsigned den;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned s;
    longint unsigned cand;
    longint unsigned p;
    longint unsigned prod;
    int b;
    int i;
    num = ((64'd8000 * 64'(k)) + (64'd55 * 64'(depth))) << 24;
    den = 64'd1055 * 64'(depth);
    u = 64'd0;
    for (b = 27; b >= 0; b--) begin
      cand = u | (64'd1 << b);
      if (cand * den <= num) u = cand;
    end
    u2 = (u * u) >> 24;
    s = 64'd0;
    for (b = 25; b >= 0; b--) begin
      cand = s | (64'd1 << b);
      p = cand;
      for (i = 0; i < 4; i++) p = (p * cand) >> 24;
      if (p <= u2) s = cand;
    end
    prod = (u2 * s + (64'd1 << 31)) >> 32;
    return KNOT_W'(prod);
  endfunction

endpackage

// ===== src/pcsd_pix_if.sv =====
// ----------------------------------------------------------------------------
// pcsd_pix_if: pixel input channel
// Valid/ready channel carrying one RGBA pixel with ambient, depth and NaN marks.
// ----------------------------------------------------------------------------
interface pcsd_pix_if;
  import pcsd_pkg::*;

  logic                valid;
  logic                ready;
  sample_t             red;
  sample_t             green;
  sample_t             blue;
  sample_t             alpha;
  sample_t             ambient;
  sample_t             depth;
  logic [FLAG_W-1:0]   nan_flags;

  modport source (output valid, red, green, blue, alpha, ambient, depth, nan_flags,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, ambient, depth, nan_flags,
                  output ready);
endinterface

// ===== src/pcsd_res_if.sv =====
// ----------------------------------------------------------------------------
// pcsd_res_if: result channel
// Valid/ready channel carrying the decoded pixel and its destination index.
// ----------------------------------------------------------------------------
interface pcsd_res_if;
  import pcsd_pkg::*;

  logic               valid;
  logic               ready;
  result_t            out_red;
  result_t            out_green;
  result_t            out_blue;
  sample_t            out_alpha;
  logic [INDEX_W-1:0] target_index;
  logic               frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, target_index,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, target_index,
                  frame_last, output ready);
endinterface

// ===== src/pcsd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pcsd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pcsd_cfg_if;
  import pcsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pixel_compose_srgb_decode.sv =====
// ----------------------------------------------------------------------------
// pixel_compose_srgb_decode: RGBA pixel composer with sRGB-to-linear decode
// Three colour lanes decode red, green and blue side by side; alpha and the
// destination index run alongside; the output register merges them into one
// result beat.
//
//   channel  role     handshake     payload
//   cfg      sink     valid/ready   index, data (always ready)
//   pixel    sink     valid/ready   red, green, blue, alpha, ambient, depth,
//                                   nan_flags
//   result   source   valid/ready   out_red, out_green, out_blue, out_alpha,
//                                   target_index, frame_last
//
// One pixel beat per cycle while the result side takes beats.
// A pixel passes four lane stages (ambient multiply, select,
// segment split, table read and interpolation product) and then the output register.
// A held result beat stalls the whole pipeline, and pixel ready drops with it.
// Synchronous reset clears configuration, frame counters and valid bits; the
// decode table is constant, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module pixel_compose_srgb_decode #(
  parameter int MAX_DIM            = 4096,
  parameter int DECODE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  pcsd_cfg_if.sink    cfg,
  pcsd_pix_if.sink    pixel,
  pcsd_res_if.source  result
);
  import pcsd_pkg::*;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             use_ambient;
  logic             use_background;
  sample_t          back_red;
  sample_t          back_green;
  sample_t          back_blue;

  logic                  adv;
  logic                  take;
  logic [PIPE_DEPTH-1:0] stage_valid;
  logic                  out_valid;
  lane_ctl_t             ctl;

  sample_t lane_in   [3];
  logic    lane_nan  [3];
  sample_t lane_back [3];
  result_t lane_res  [3];

  sample_t alpha_pipe [PIPE_DEPTH];

  result_t            res_red;
  result_t            res_green;
  result_t            res_blue;
  sample_t            res_alpha;
  logic [INDEX_W-1:0] res_index;
  logic               res_last;
  logic [INDEX_W-1:0] idx_tgt;
  logic               idx_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= DIM_W'(1);
      frame_height   <= DIM_W'(1);
      use_ambient    <= 1'b0;
      use_background <= 1'b0;
      back_red       <= '0;
      back_green     <= '0;
      back_blue      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:    frame_width    <= cfg.data[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg.data[DIM_W-1:0];
        REG_USE_AMBIENT:    use_ambient    <= cfg.data[0];
        REG_USE_BACKGROUND: use_background <= cfg.data[0];
        REG_BACK_RED:       back_red       <= signed'(cfg.data[SAMPLE_W-1:0]);
        REG_BACK_GREEN:     back_green     <= signed'(cfg.data[SAMPLE_W-1:0]);
        REG_BACK_BLUE:      back_blue      <= signed'(cfg.data[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  assign adv         = !out_valid || result.ready;
  assign take        = pixel.valid && adv;
  assign pixel.ready = adv;

  assign ctl.use_amb = use_ambient;
  assign ctl.amb_nan = pixel.nan_flags[NAN_AMBIENT];
  assign ctl.is_back = use_background && !pixel.nan_flags[NAN_DEPTH] &&
                       (pixel.depth == ONE_Q16);

  assign lane_in[0]   = pixel.red;
  assign lane_in[1]   = pixel.green;
  assign lane_in[2]   = pixel.blue;
  assign lane_nan[0]  = pixel.nan_flags[NAN_RED];
  assign lane_nan[1]  = pixel.nan_flags[NAN_GREEN];
  assign lane_nan[2]  = pixel.nan_flags[NAN_BLUE];
  assign lane_back[0] = back_red;
  assign lane_back[1] = back_green;
  assign lane_back[2] = back_blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pcsd_lane #(
      .TABLE_DEPTH (DECODE_TABLE_DEPTH)
    ) u_lane (
      .clk        (clk),
      .adv        (adv),
      .ctl        (ctl),
      .sample     (lane_in[c]),
      .sample_nan (lane_nan[c]),
      .ambient    (pixel.ambient),
      .back       (lane_back[c]),
      .result     (lane_res[c])
    );
  end

  pcsd_index #(
    .MAX_DIM (MAX_DIM)
  ) u_index (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .take         (take),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .target_index (idx_tgt),
    .frame_last   (idx_last)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_pipe[0] <= pixel.nan_flags[NAN_ALPHA] ? '0 : pixel.alpha;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        alpha_pipe[i] <= alpha_pipe[i-1];
      end
      res_red   <= lane_res[0];
      res_green <= lane_res[1];
      res_blue  <= lane_res[2];
      res_alpha <= alpha_pipe[PIPE_DEPTH-1];
      res_index <= idx_tgt;
      res_last  <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[PIPE_DEPTH-2:0], take};
      out_valid   <= stage_valid[PIPE_DEPTH-1];
    end
  end

  assign result.valid        = out_valid;
  assign result.out_red      = res_red;
  assign result.out_green    = res_green;
  assign result.out_blue     = res_blue;
  assign result.out_alpha    = res_alpha;
  assign result.target_index = res_index;
  assign result.frame_last   = res_last;

`ifndef SYNTHESIS
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid[PIPE_DEPTH-1]))
    else $error("result beat with no item in the last lane stage");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_red >= OUT_MIN && res_red <= OUT_MAX &&
                   res_green >= OUT_MIN && res_green <= OUT_MAX &&
                   res_blue >= OUT_MIN && res_blue <= OUT_MAX))
    else $error("decoded colour outside saturation range");
`endif

endmodule

// ===== src/pcsd_lane.sv =====
// ----------------------------------------------------------------------------
// pcsd_lane: one colour lane
// NaN mask, ambient multiply, background select and sRGB-to-linear decode
// (linear segment by reciprocal multiply, power segment by knot interpolation)
// over four pipeline stages that advance together.
// ----------------------------------------------------------------------------
module pcsd_lane #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                adv,
  input  pcsd_pkg::lane_ctl_t ctl,
  input  pcsd_pkg::sample_t   sample,
  input  logic                sample_nan,
  input  pcsd_pkg::sample_t   ambient,
  input  pcsd_pkg::sample_t   back,
  output pcsd_pkg::result_t   result
);
  import pcsd_pkg::*;

  localparam int KIDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W  = FRAC_W + KIDX_W;
  localparam int IP_W   = KNOT_W + FRAC_W;
  localparam int RCP_W  = 2 * LIN_M_W;

  logic [KNOT_W-1:0] knot_tab [TABLE_DEPTH+1];

  for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_knot
    localparam logic [KNOT_W-1:0] KV = knot_value(TABLE_DEPTH, k);
    assign knot_tab[k] = KV;
  end

  // stage 1: mask and ambient product
  sample_t                   val0;
  logic signed [PROD_W-1:0]  prod0;
  logic signed [PROD_W-1:0]  s1_prod;
  sample_t                   s1_val;
  lane_ctl_t                 s1_ctl;

  assign val0  = sample_nan ? '0 : sample;
  assign prod0 = PROD_W'(val0) * PROD_W'(ambient);

  // stage 2: round, saturate, select
  logic signed [PROD_W-1:0]  rnd;
  sample_t                   amb_val;
  sample_t                   sel_val;
  sample_t                   s2_v;

  assign rnd = (s1_prod + PROD_W'(32768)) >>> 16;

  always_comb begin
    if (rnd > PROD_W'(Q_MAX)) begin
      amb_val = Q_MAX;
    end else if (rnd < PROD_W'(Q_MIN)) begin
      amb_val = Q_MIN;
    end else begin
      amb_val = SAMPLE_W'(rnd);
    end
    if (s1_ctl.is_back) begin
      sel_val = back;
    end else if (s1_ctl.use_amb) begin
      sel_val = s1_ctl.amb_nan ? '0 : amb_val;
    end else begin
      sel_val = s1_val;
    end
  end

  // stage 3: segment pick, linear numerator, table position
  logic signed [LIN_X_W-1:0] lin_x;
  logic [POS_W-1:0]          pos;
  logic                      s3_lin;
  logic [LIN_M_W-1:0]        s3_m;
  logic [KIDX_W-1:0]         s3_idx;
  logic [FRAC_W-1:0]         s3_frac;

  assign lin_x = LIN_X_W'(s2_v) * LIN_SLOPE + LIN_BIAS;
  assign pos   = POS_W'(s2_v[FRAC_W-1:0]) * POS_W'(TABLE_DEPTH);

  // stage 4: reciprocal multiply, knot read, interpolation product
  logic [RCP_W-1:0]          recip;
  logic [KIDX_W-1:0]         idx_hi;
  logic [KNOT_W-1:0]         knot_lo;
  logic [KNOT_W-1:0]         knot_diff;
  logic [IP_W-1:0]           ip;
  logic                      s4_lin;
  logic [QUOT_W-1:0]         s4_q;
  logic [KNOT_W-1:0]         s4_lo;
  logic [IP_W-1:0]           s4_ip;

  assign recip     = RCP_W'(s3_m) * RCP_W'(LIN_RECIP);
  assign idx_hi    = s3_idx + KIDX_W'(1);
  assign knot_lo   = knot_tab[s3_idx];
  assign knot_diff = knot_tab[idx_hi] - knot_lo;
  assign ip        = IP_W'(knot_diff) * IP_W'(s3_frac);

  // output: finish interpolation or linear segment, saturate
  logic [IP_W-1:0]            ip_rnd;
  logic signed [RES_X_W-1:0]  interp;
  logic signed [RES_X_W-1:0]  lin_r;
  logic signed [RES_X_W-1:0]  pick;

  assign ip_rnd = s4_ip + (IP_W'(1) << (FRAC_W - 1));
  assign interp = signed'(RES_X_W'(s4_lo) + RES_X_W'(ip_rnd[IP_W-1:FRAC_W]));
  assign lin_r  = signed'(RES_X_W'(s4_q) - LIN_OFFS);
  assign pick   = s4_lin ? lin_r : interp;

  always_comb begin
    if (pick > RES_X_W'(OUT_MAX)) begin
      result = OUT_MAX;
    end else if (pick < RES_X_W'(OUT_MIN)) begin
      result = OUT_MIN;
    end else begin
      result = RESULT_W'(pick);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod <= prod0;
      s1_val  <= val0;
      s1_ctl  <= ctl;
      s2_v    <= sel_val;
      s3_lin  <= (s2_v <= LIN_LIMIT);
      s3_m    <= lin_x[LIN_M_W-1:0];
      s3_idx  <= pos[POS_W-1:FRAC_W];
      s3_frac <= pos[FRAC_W-1:0];
      s4_lin  <= s3_lin;
      s4_q    <= recip[LIN_SHIFT +: QUOT_W];
      s4_lo   <= knot_lo;
      s4_ip   <= ip;
    end
  end

endmodule

// ===== src/pcsd_index.sv =====
// ----------------------------------------------------------------------------
// pcsd_index: frame position and destination index
// Row and column counters over the clamped frame size, the flipped and
// transposed destination index, the end-of-frame mark, and a delay line that
// keeps both in step with the colour lanes.
// ----------------------------------------------------------------------------
module pcsd_index #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         take,
  input  logic [pcsd_pkg::DIM_W-1:0]   frame_width,
  input  logic [pcsd_pkg::DIM_W-1:0]   frame_height,
  output logic [pcsd_pkg::INDEX_W-1:0] target_index,
  output logic                         frame_last
);
  import pcsd_pkg::*;

  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIMV_W = $clog2(MAX_DIM + 1);
  localparam int EXT_W  = (DIMV_W > DIM_W) ? DIMV_W : DIM_W;
  localparam int TGT_W  = DIMV_W + CNT_W + 1;

  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  column_count_next;
  logic [CNT_W-1:0]  row_count_next;
  logic [EXT_W-1:0]  fw_x;
  logic [EXT_W-1:0]  fh_x;
  logic [DIMV_W-1:0] w;
  logic [DIMV_W-1:0] h;
  logic [CNT_W-1:0]  col_eff;
  logic [CNT_W-1:0]  row_eff;
  logic [DIMV_W-1:0] col_inc;
  logic [DIMV_W-1:0] row_inc;
  logic [TGT_W-1:0]  tgt;
  logic              last_now;

  logic [INDEX_W-1:0] tgt_pipe  [PIPE_DEPTH];
  logic               last_pipe [PIPE_DEPTH];

  assign fw_x = EXT_W'(frame_width);
  assign fh_x = EXT_W'(frame_height);

  always_comb begin
    if (fw_x == '0) begin
      w = DIMV_W'(1);
    end else if (fw_x > EXT_W'(MAX_DIM)) begin
      w = DIMV_W'(MAX_DIM);
    end else begin
      w = DIMV_W'(fw_x);
    end
    if (fh_x == '0) begin
      h = DIMV_W'(1);
    end else if (fh_x > EXT_W'(MAX_DIM)) begin
      h = DIMV_W'(MAX_DIM);
    end else begin
      h = DIMV_W'(fh_x);
    end
  end

  assign col_eff = (DIMV_W'(column_count) >= w) ? '0 : column_count;
  assign row_eff = (DIMV_W'(row_count) >= h) ? '0 : row_count;
  assign col_inc = DIMV_W'(col_eff) + DIMV_W'(1);
  assign row_inc = DIMV_W'(row_eff) + DIMV_W'(1);

  always_comb begin
    if (row_inc >= h) begin
      row_count_next    = '0;
      column_count_next = (col_inc >= w) ? '0 : CNT_W'(col_inc);
    end else begin
      row_count_next    = CNT_W'(row_inc);
      column_count_next = col_eff;
    end
  end

  assign tgt = TGT_W'(h) - TGT_W'(1) - TGT_W'(row_eff) + TGT_W'(h) * TGT_W'(col_eff);
  assign last_now = (DIMV_W'(col_eff) == w - DIMV_W'(1)) &&
                    (DIMV_W'(row_eff) == h - DIMV_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tgt_pipe[0]  <= INDEX_W'(tgt);
      last_pipe[0] <= last_now;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        tgt_pipe[i]  <= tgt_pipe[i-1];
        last_pipe[i] <= last_pipe[i-1];
      end
    end
  end

  assign target_index = tgt_pipe[PIPE_DEPTH-1];
  assign frame_last   = last_pipe[PIPE_DEPTH-1];

endmodule
